// File: hw/rtl/glbr_pkg.sv
// Shared constants and types for the gradient line blend renderer.
`timescale 1ns / 1ps
package glbr_pkg;
	localparam int DISPLAY_WIDTH_DEF  = 16;
	localparam int DISPLAY_HEIGHT_DEF = 16;
	localparam int MAX_LINE = 16;
	localparam int COLW = 4;
	localparam int CNTW = 5;

	typedef struct packed {
		logic [3:0] start_col;
		logic [3:0] row;
		logic [4:0] line_width;
		logic [7:0] start_red;
		logic [7:0] start_green;
		logic [7:0] start_blue;
		logic [7:0] start_alpha;
		logic [7:0] end_red;
		logic [7:0] end_green;
		logic [7:0] end_blue;
		logic [7:0] end_alpha;
	} line_cmd_t;

	typedef struct packed {
		logic [7:0] pixel_index;
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       last_pixel;
	} pixel_wr_t;

	// blend old towards fresh by alpha/256, rounding towards minus infinity
	function automatic logic [7:0] blend(input logic [7:0] old, input logic [7:0] fresh,
			input logic [7:0] alpha);
		logic signed [17:0] d;
		d = ($signed({1'b0, fresh}) - $signed({1'b0, old})) * $signed({1'b0, alpha});
		return old + d[15:8];
	endfunction
endpackage

// File: hw/rtl/glbr_if.sv
// Valid/ready channel interfaces for line commands and pixel writes.
`timescale 1ns / 1ps
interface glbr_cmd_if;
	logic valid;
	logic ready;
	glbr_pkg::line_cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface glbr_pix_if;
	logic valid;
	logic ready;
	glbr_pkg::pixel_wr_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/gradient_line_blend_renderer.sv
// Top level: gradient line renderer with alpha blend into a serpentine frame store.
`timescale 1ns / 1ps
// Line commands are taken one at a time. After a command is accepted, a shared restoring
// divider works out the four colour steps one quotient bit per cycle, component by
// component, and does no division when the width is one. Each pixel then goes through a
// read of the frame store, a blend, and a write back while the pixel write is loaded into
// the output register. A command of width zero is accepted and draws nothing. After reset
// a clearing pass zeroes the whole store; no command is taken until it ends. Pixel writes
// wait in an output register; the pixel walk stalls while that register is full and
// moves on in the cycle after the write is taken.
module gradient_line_blend_renderer #(
	parameter int DISPLAY_WIDTH  = glbr_pkg::DISPLAY_WIDTH_DEF,
	parameter int DISPLAY_HEIGHT = glbr_pkg::DISPLAY_HEIGHT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	glbr_cmd_if.sink   cmd,
	glbr_pix_if.source pix
);
	localparam int NPIX = DISPLAY_WIDTH * DISPLAY_HEIGHT;
	localparam int AW = $clog2(NPIX);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_BL   = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0] state_q;
	logic [AW:0] clr_q;
	glbr_pkg::line_cmd_t cmd_q;
	logic [4:0] cnt_q;        // saturated width
	logic [4:0] j_q;          // pixel counter
	logic [1:0] comp_q;       // component under division
	logic [2:0] bit_q;        // divider bit
	logic [8:0] val_q [4];    // current values (signed 9 bits)
	logic [7:0] quo_q [4];    // quotient magnitude
	logic [3:0] rem_q [4];
	logic [3:0] frac_q [4];
	logic       neg_q [4];
	logic [4:0] dv_rem_q;
	logic [7:0] dv_num_q;
	logic [23:0] mem [NPIX];
	logic [23:0] rd_s1;
	logic [23:0] newpx_q;
	logic [AW-1:0] addr_q;
	logic last_q;
	logic pv_q;
	glbr_pkg::pixel_wr_t pd_q;

	logic [3:0] den;
	assign den = 4'(cnt_q - 5'd1);

	// address of the current pixel
	logic [5:0] col;
	logic       col_ok;
	logic [6:0] scol;
	logic [12:0] pixa;
	assign col = 6'(cmd_q.start_col) + 6'(j_q);
	assign col_ok = 32'(col) < DISPLAY_WIDTH;
	assign scol = cmd_q.row[0] ? 7'(col) : 7'(DISPLAY_WIDTH - 1) - 7'(col);
	assign pixa = 13'(cmd_q.row) * 13'(DISPLAY_WIDTH) + 13'(scol);

	// any later visible pixel in this line
	logic more;
	always_comb begin
		more = 1'b0;
		for (int k = 1; k < glbr_pkg::MAX_LINE; k++)
			if (5'(j_q) + 5'(k) < cnt_q &&
				32'(6'(cmd_q.start_col) + 6'(j_q) + 6'(k)) < DISPLAY_WIDTH)
				more = 1'b1;
	end

	logic [7:0] sv [4];
	logic [7:0] ev [4];
	assign sv = '{cmd_q.start_red, cmd_q.start_green, cmd_q.start_blue, cmd_q.start_alpha};
	assign ev = '{cmd_q.end_red, cmd_q.end_green, cmd_q.end_blue, cmd_q.end_alpha};

	logic [7:0] mag;
	assign mag = (ev[comp_q] >= sv[comp_q]) ? ev[comp_q] - sv[comp_q] : sv[comp_q] - ev[comp_q];

	assign cmd.ready = state_q == ST_IDLE;
	assign pix.valid = pv_q;
	assign pix.data = pd_q;

	// frame store port
	always_ff @(posedge clk) begin
		if (state_q == ST_CLR)
			mem[clr_q[AW-1:0]] <= '0;
		else if (state_q == ST_OUT && !pv_q && col_ok)
			mem[addr_q] <= newpx_q;
		rd_s1 <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			pv_q <= 1'b0;
		end else begin
			if (pv_q && pix.ready) pv_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == NPIX - 1) state_q <= ST_IDLE;
				end
				ST_IDLE: if (cmd.valid) begin
					cmd_q <= cmd.data;
					cnt_q <= (cmd.data.line_width > 5'd16) ? 5'd16 : cmd.data.line_width;
					j_q <= '0;
					comp_q <= '0;
					bit_q <= '0;
					dv_rem_q <= '0;
					if (cmd.data.line_width != 0 && 32'(cmd.data.row) < DISPLAY_HEIGHT)
						state_q <= ST_DIV;
				end
				// one quotient bit per cycle, per component
				ST_DIV: begin
					if (bit_q == 3'd0 && dv_rem_q == 5'd0 && cnt_q <= 5'd1) begin
						for (int c = 0; c < 4; c++) begin
							val_q[c] <= {1'b0, sv[c]};
							quo_q[c] <= '0; rem_q[c] <= '0; frac_q[c] <= '0; neg_q[c] <= 1'b0;
						end
						state_q <= ST_RD;
						addr_q <= AW'(pixa);
					end else begin
						logic [7:0] n;
						logic [4:0] r;
						n = (bit_q == 0) ? mag : dv_num_q;
						r = (bit_q == 0) ? 5'd0 : dv_rem_q;
						r = {r[3:0], n[7]};
						n = {n[6:0], 1'b0};
						if (r >= 5'(den)) begin r = r - 5'(den); n[0] = 1'b1; end
						dv_num_q <= n;
						dv_rem_q <= r;
						bit_q <= bit_q + 1'b1;
						if (bit_q == 3'd7) begin
							val_q[comp_q] <= {1'b0, sv[comp_q]};
							quo_q[comp_q] <= n;
							rem_q[comp_q] <= r[3:0];
							frac_q[comp_q] <= den >> 1;
							neg_q[comp_q] <= ev[comp_q] < sv[comp_q];
							comp_q <= comp_q + 1'b1;
							if (comp_q == 2'd3) begin
								state_q <= ST_RD;
								addr_q <= AW'(pixa);
							end
						end
					end
				end
				ST_RD: state_q <= ST_BL;
				ST_BL: begin
					newpx_q <= {glbr_pkg::blend(rd_s1[23:16], val_q[0][7:0], val_q[3][7:0]),
						glbr_pkg::blend(rd_s1[15:8], val_q[1][7:0], val_q[3][7:0]),
						glbr_pkg::blend(rd_s1[7:0], val_q[2][7:0], val_q[3][7:0])};
					last_q <= !more;
					state_q <= ST_OUT;
				end
				ST_OUT: if (!pv_q) begin
					if (col_ok) begin
						pv_q <= 1'b1;
						pd_q <= '{pixel_index: 8'(pixa), red_out: newpx_q[23:16],
							green_out: newpx_q[15:8], blue_out: newpx_q[7:0],
							last_pixel: last_q};
					end
					// advance the DDA
					for (int c = 0; c < 4; c++) if (cnt_q > 5'd1) begin
						logic [4:0] f;
						logic step;
						f = 5'(frac_q[c]) + 5'(rem_q[c]);
						step = f >= 5'(den);
						frac_q[c] <= step ? 4'(f - 5'(den)) : f[3:0];
						val_q[c] <= neg_q[c] ? val_q[c] - 9'(quo_q[c]) - 9'(step)
							: val_q[c] + 9'(quo_q[c]) + 9'(step);
					end
					j_q <= j_q + 1'b1;
					if (j_q + 5'd1 >= cnt_q) state_q <= ST_IDLE;
					else begin
						state_q <= ST_RD;
						addr_q <= AW'(13'(cmd_q.row) * 13'(DISPLAY_WIDTH) + (cmd_q.row[0]
							? 13'(col + 6'd1) : 13'(DISPLAY_WIDTH - 1) - 13'(col + 6'd1)));
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && !pix.ready |=> pix.valid && $stable(pix.data))
		else $error("pixel write changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR |-> !cmd.ready)
		else $error("command taken during clear");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> j_q < cnt_q)
		else $error("pixel counter overran");
endmodule
